### rtl/core/pmb_pkg.sv
`timescale 1ns / 1ps

package pmb_pkg;

  // Default for the top level parameter.
  localparam int COORD_WIDTH_DEF = 32;

  // Command and register codes.
  localparam logic CMD_PROJECT = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;
  localparam logic [4:0] NUM_COEF = 5'd16;
  localparam logic [4:0] CAM_END  = 5'd19;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PLAYER = 2'd0;
  localparam kind_t KIND_NPC    = 2'd1;

  localparam int DIM_W = 14;
  localparam logic [DIM_W-1:0] SCREEN_W_RST = 14'd1920;
  localparam logic [DIM_W-1:0] SCREEN_H_RST = 14'd1080;

  // Datapath widths.
  localparam int PROD_W = 56;            // 32x32 product after floor shift by 8
  localparam int CLIP_W = 58;            // clip coordinate, signed
  localparam int CAP_W  = 21;            // capped |difference|
  localparam logic [CAP_W-1:0] DIFF_CAP = 21'h100000;
  localparam int SQ_W   = 44;            // sum of squares, even width
  localparam int ROOT_W = SQ_W / 2;
  localparam int ANC_VW = 40;            // divisor width after normalizing
  localparam int ANC_Q  = 18;            // anchor quotient bits
  localparam int SIZE_VW = 22;
  localparam int SIZE_Q  = 13;
  localparam int BOX_W  = 11;
  localparam int OUT_W  = 17;

  // Pipeline stage numbers (stage 1 is the register written at input accept).
  localparam int ST_VIS  = 3;
  localparam int ST_ANC  = ST_VIS + 3 + ANC_Q;
  localparam int ST_ROOT = ST_VIS + ROOT_W;
  localparam int ST_SIZE = ST_ROOT + SIZE_Q + 2;
  localparam int ST_OUT  = ST_SIZE + 1;

  // Size table.
  localparam logic [SIZE_VW-1:0] DEN_OFFSET = 22'd2560;
  localparam int SZ_DW = SIZE_VW + SIZE_Q;
  localparam logic [SZ_DW-1:0] K_PLAYER = 35'd16384000;
  localparam logic [SZ_DW-1:0] K_NPC    = 35'd9830400;
  localparam logic [SZ_DW-1:0] K_GADGET = 35'd1638400;

  function automatic logic [OUT_W-1:0] sat17(input logic signed [19:0] v);
    logic [OUT_W-1:0] r;
    if (v < -20'sd65536) begin
      r = 17'h10000;
    end else if (v > 20'sd65535) begin
      r = 17'h0FFFF;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/projected_marker_box_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready  | tdata: coef_index, coef_value, world_x/y/z
//         |     |                      | tuser: command, entity_kind
// out_    | out | out_tvalid/out_tready| tdata: anchors, box size, box corners
//         |     |                      | tuser: visible
// cfg_    | in  | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One word is accepted per cycle while the output is not stalled. A project
// word yields its result word in the output register; the longest path is the
// distance square root (22 stages) followed by the size divider (13 stages).
// Load words update the coefficients at accept and produce no result.
// Reset (rst_n low, synchronous) empties the pipeline, clears the matrix and
// camera words and restores the 1920 x 1080 viewport.
// When the output word is not taken the whole pipeline holds, in_tready
// drops and nothing in flight is lost or repeated.
module projected_marker_box_top
  import pmb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // coef_index[4:0], coef_value[36:5], world_x[68:37], world_y[100:69],
  // world_z[132:101], zero fill [135:133]
  input  logic [135:0] in_tdata,
  // command[0], entity_kind[2:1]
  input  logic [2:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // anchor_x[16:0], anchor_y[33:17], box_width[44:34], box_height[55:45],
  // box_min_x[72:56], box_min_y[89:73], box_max_x[106:90], box_max_y[123:107],
  // zero fill [127:124]
  output logic [127:0] out_tdata,
  // visible[0]
  output logic [0:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata
);

  // World and camera words are signed values of CE bits.
  localparam int CE = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int SH = 32 - CE;

  logic               adv;
  logic               in_acc;
  logic [4:0]         coef_idx;
  logic signed [31:0] coef_val;
  logic signed [31:0] world [3];
  logic               cmd;
  kind_t              in_kind;

  logic [DIM_W-1:0]   screen_w_r, screen_h_r;
  logic [31:0]        coef_r [16];
  logic [31:0]        cam_r  [3];

  logic               valid_r [1:ST_OUT];
  kind_t              kind_r  [1:ST_ROOT];
  logic               vis_r   [ST_VIS:ST_SIZE];

  // Stage 1 to 3 datapath
  logic signed [31:0]     p_c   [3];
  logic signed [31:0]     cam_c [3];
  logic signed [63:0]     prod_c [4][3];
  logic signed [PROD_W-1:0] pr_r [4][3];
  logic signed [31:0]     cterm_r [4];
  logic signed [CLIP_W-1:0] clip_c [4];
  logic signed [CLIP_W-1:0] clip_r [4];
  logic [CAP_W-1:0]       dist_c [3];
  logic [CAP_W-1:0]       dist_r [3];
  logic [2*CAP_W-1:0]     sq_r   [3];
  logic [SQ_W-1:0]        sum_r;
  logic                   vis_c;
  logic [CLIP_W-1:0]      nx_r, ny_r, w_r;

  logic [ANC_Q-1:0]       ax_q, ay_q;
  logic [ANC_Q-1:0]       axd_r [ST_ANC+1:ST_SIZE];
  logic [ANC_Q-1:0]       ayd_r [ST_ANC+1:ST_SIZE];
  logic [ROOT_W-1:0]      root;
  logic [BOX_W-1:0]       box_w, box_h;
  kind_t                  box_kind;

  logic signed [19:0]     ax_w, ay_w, hw_w, bh_w, hh_w;
  logic signed [19:0]     mnx_w, mny_w, mxx_w, mxy_w;
  logic [127:0]           odata_nxt, odata_r;
  logic                   ovis_r;

  // The output register is the only place a finished word waits; everything
  // upstream moves whenever it is empty or being taken.
  assign adv       = !valid_r[ST_OUT] || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  assign coef_idx = in_tdata[4:0];
  assign coef_val = in_tdata[36:5];
  assign world[0] = in_tdata[68:37];
  assign world[1] = in_tdata[100:69];
  assign world[2] = in_tdata[132:101];
  assign cmd      = in_tuser[0];
  assign in_kind  = in_tuser[2:1];

  // Configuration and coefficient storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= SCREEN_W_RST;
      screen_h_r <= SCREEN_H_RST;
      for (int i = 0; i < 16; i++) begin
        coef_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        cam_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  screen_w_r <= cfg_wdata;
          REG_SCREEN_HEIGHT: screen_h_r <= cfg_wdata;
        endcase
      end
      if (in_acc && cmd == CMD_LOAD) begin
        if (coef_idx < NUM_COEF) begin
          coef_r[coef_idx[3:0]] <= coef_val;
        end else if (coef_idx < CAM_END) begin
          cam_r[2'(coef_idx - NUM_COEF)] <= coef_val;
        end
      end
    end
  end

  // Stage 1: matrix products and capped camera differences, taken from the
  // coefficients as they stand when the word is accepted.
  always_comb begin
    logic signed [31:0] t;
    logic signed [32:0] d;
    logic [32:0]        ad;
    for (int c = 0; c < 3; c++) begin
      t        = world[c] <<< SH;
      p_c[c]   = t >>> SH;
      t        = cam_r[c] <<< SH;
      cam_c[c] = t >>> SH;
      d        = 33'(p_c[c]) - 33'(cam_c[c]);
      ad       = d[32] ? 33'(-d) : 33'(d);
      dist_c[c] = (ad > 33'(DIFF_CAP)) ? DIFF_CAP : CAP_W'(ad);
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_c[r][c] = signed'(coef_r[r*4+c]) * p_c[c];
      end
    end
  end

  // Stage 2: clip coordinates.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      clip_c[r] = CLIP_W'(pr_r[r][0]) + CLIP_W'(pr_r[r][1]) + CLIP_W'(pr_r[r][2])
                + CLIP_W'(cterm_r[r]);
    end
  end

  // Stage 3: view volume test, exact on the clip coordinates.
  assign vis_c = (clip_r[3] > 0)
              && (clip_r[0] >= -clip_r[3]) && (clip_r[0] <= clip_r[3])
              && (clip_r[1] >= -clip_r[3]) && (clip_r[1] <= clip_r[3])
              && (clip_r[2] >= 0) && (clip_r[2] <= clip_r[3]);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          pr_r[r][c] <= prod_c[r][c][63:8];
        end
        cterm_r[r] <= coef_r[r*4+3];
        clip_r[r]  <= clip_c[r];
      end
      for (int c = 0; c < 3; c++) begin
        dist_r[c] <= dist_c[c];
        sq_r[c]   <= (2*CAP_W)'(dist_r[c]) * (2*CAP_W)'(dist_r[c]);
      end
      sum_r <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
      nx_r  <= CLIP_W'(clip_r[0] + clip_r[3]);
      ny_r  <= CLIP_W'(clip_r[3] - clip_r[1]);
      w_r   <= clip_r[3];
    end
  end

  // Screen anchors, one unit per axis (Y is flipped through w - y).
  pmb_anchor u_anchor_x (
    .clk(clk), .en(adv), .num(nx_r), .den(w_r), .dim(screen_w_r), .q(ax_q)
  );

  pmb_anchor u_anchor_y (
    .clk(clk), .en(adv), .num(ny_r), .den(w_r), .dim(screen_h_r), .q(ay_q)
  );

  // Camera distance and box size.
  pmb_isqrt u_isqrt (
    .clk(clk), .en(adv), .rad(sum_r), .root(root)
  );

  pmb_size u_size (
    .clk     (clk),
    .en      (adv),
    .cam_dist(root),
    .kind    (kind_r[ST_ROOT]),
    .box_w   (box_w),
    .box_h   (box_h),
    .kind_o  (box_kind)
  );

  // Control chains: valid, kind and visibility travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= ST_OUT; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else if (adv) begin
      valid_r[1] <= in_tvalid && (cmd == CMD_PROJECT);
      for (int k = 2; k <= ST_OUT; k++) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r[1] <= in_kind;
      for (int k = 2; k <= ST_ROOT; k++) begin
        kind_r[k] <= kind_r[k-1];
      end
      vis_r[ST_VIS] <= vis_c;
      for (int k = ST_VIS + 1; k <= ST_SIZE; k++) begin
        vis_r[k] <= vis_r[k-1];
      end
      axd_r[ST_ANC+1] <= ax_q;
      ayd_r[ST_ANC+1] <= ay_q;
      for (int k = ST_ANC + 2; k <= ST_SIZE; k++) begin
        axd_r[k] <= axd_r[k-1];
        ayd_r[k] <= ayd_r[k-1];
      end
    end
  end

  // Final stage: box corners around the unsaturated anchor, then saturation.
  // Player and NPC boxes stand on the anchor; gadget boxes are centered.
  always_comb begin
    ax_w = signed'(20'(axd_r[ST_SIZE]));
    ay_w = signed'(20'(ayd_r[ST_SIZE]));
    hw_w = signed'(20'(box_w >> 1));
    bh_w = signed'(20'(box_h));
    hh_w = signed'(20'(box_h >> 1));
    mnx_w = ax_w - hw_w;
    mxx_w = ax_w + hw_w;
    case (box_kind)
      KIND_PLAYER, KIND_NPC: begin
        mny_w = ay_w - bh_w;
        mxy_w = ay_w;
      end
      default: begin
        mny_w = ay_w - hh_w;
        mxy_w = ay_w + hh_w;
      end
    endcase
    odata_nxt = '0;
    if (vis_r[ST_SIZE]) begin
      odata_nxt[16:0]    = sat17(ax_w);
      odata_nxt[33:17]   = sat17(ay_w);
      odata_nxt[44:34]   = box_w;
      odata_nxt[55:45]   = box_h;
      odata_nxt[72:56]   = sat17(mnx_w);
      odata_nxt[89:73]   = sat17(mny_w);
      odata_nxt[106:90]  = sat17(mxx_w);
      odata_nxt[123:107] = sat17(mxy_w);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      odata_r <= odata_nxt;
      ovis_r  <= vis_r[ST_SIZE];
    end
  end

  assign out_tdata  = odata_r;
  assign out_tuser  = ovis_r;
  assign out_tvalid = valid_r[ST_OUT];

  // A waiting result word must hold the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // A rejected point carries an all-zero payload.
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("rejected point with nonzero payload");

  // Every visible box height is at least the smallest clamp.
  a_min_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[55:45] >= 11'd64)
    else $error("box height below minimum");

  // A load word never enters the result pipeline.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !valid_r[1])
    else $error("load word produced a result");

  // The X corners stay ordered after saturation.
  a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      signed'(out_tdata[72:56]) <= signed'(out_tdata[106:90]))
    else $error("box corners out of order");

endmodule

### rtl/core/pmb_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The dividend must be below dvs * 2**QW.
module pmb_div #(
  parameter int VW = 22,
  parameter int QW = 13
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW+QW-1:0] dvd,
  input  logic [VW-1:0] dvs,
  output logic [QW-1:0] q
);

  localparam int W = VW + QW;

  logic [W-1:0]  rem_r [QW];
  logic [VW-1:0] dvs_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [W-1:0]  rem_in;
    logic [VW-1:0] dvs_in;
    logic [QW-1:0] q_in;
    logic [W:0]    diff;

    if (i == 0) begin : g_first
      assign rem_in = dvd;
      assign dvs_in = dvs;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dvs_in = dvs_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign diff = {1'b0, rem_in} - ({1'b0, W'(dvs_in)} << (QW - 1 - i));

    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[i] <= dvs_in;
        if (!diff[W]) begin
          rem_r[i] <= diff[W-1:0];
          q_r[i]   <= q_in | (QW'(1) << (QW - 1 - i));
        end else begin
          rem_r[i] <= rem_in;
          q_r[i]   <= q_in;
        end
      end
    end
  end

  assign q = q_r[QW-1];

endmodule

### rtl/core/pmb_anchor.sv
`timescale 1ns / 1ps

// round(8 * dim * num / den) with both operands first scaled down until den
// fits in ANC_VW bits; the scaled operands are registered ahead of the divider.
module pmb_anchor
  import pmb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CLIP_W-1:0] num,
  input  logic [CLIP_W-1:0] den,
  input  logic [DIM_W-1:0]  dim,
  output logic [ANC_Q-1:0]  q
);

  localparam int EXT  = CLIP_W - ANC_VW;
  localparam int SH_W = $clog2(EXT + 1);
  localparam int NW   = ANC_VW + 2;
  localparam int PW   = NW + DIM_W;
  localparam int DW   = ANC_VW + ANC_Q;

  logic [SH_W-1:0]   s_nxt, s_r;
  logic [CLIP_W-1:0] num_a_r, den_a_r;
  logic [NW-1:0]     num_b_r;
  logic [ANC_VW-1:0] den_b_r, den_c_r;
  logic [PW-1:0]     prod;
  logic [DW-1:0]     dvd_nxt, dvd_r;

  // Shift count: how far the divisor sits above ANC_VW bits.
  always_comb begin
    s_nxt = '0;
    for (int k = 0; k < EXT; k++) begin
      if (den[ANC_VW+k]) begin
        s_nxt = SH_W'(k + 1);
      end
    end
  end

  assign prod    = PW'(num_b_r) * PW'(dim);
  assign dvd_nxt = DW'({prod, 3'b000}) + DW'(den_b_r >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r     <= s_nxt;
      num_a_r <= num;
      den_a_r <= den;
      num_b_r <= NW'(num_a_r >> s_r);
      den_b_r <= ANC_VW'(den_a_r >> s_r);
      dvd_r   <= dvd_nxt;
      den_c_r <= den_b_r;
    end
  end

  pmb_div #(
    .VW(ANC_VW),
    .QW(ANC_Q)
  ) u_div (
    .clk(clk),
    .en (en),
    .dvd(dvd_r),
    .dvs(den_c_r),
    .q  (q)
  );

endmodule

### rtl/core/pmb_isqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root, two radicand bits per stage.
module pmb_isqrt
  import pmb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   rad,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 3;

  logic [SQ_W-1:0]   rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_st
    logic [SQ_W-1:0]   rad_in;
    logic [REM_W-1:0]  rem_in, rem_sh;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W:0]    diff;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
    assign diff   = {1'b0, rem_sh} - (REM_W+1)'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i] <= rad_in << 2;
        if (!diff[REM_W]) begin
          rem_r[i]  <= diff[REM_W-1:0];
          root_r[i] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[i]  <= rem_sh;
          root_r[i] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

### rtl/core/pmb_size.sv
`timescale 1ns / 1ps

// Box size from camera distance: round(K / (d + 2560)), clamped per kind.
// The divider operands and the clamped sizes are registered on either side of the divider.
module pmb_size
  import pmb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] cam_dist,
  input  kind_t             kind,
  output logic [BOX_W-1:0]  box_w,
  output logic [BOX_W-1:0]  box_h,
  output kind_t             kind_o
);

  logic [SIZE_VW-1:0] den_nxt, den_r;
  logic [SZ_DW-1:0]   k_sel, dvd_nxt, dvd_r;
  kind_t              kind_r [SIZE_Q+1];
  logic [SIZE_Q-1:0]  raw;
  logic [BOX_W-1:0]   bw_nxt, bh_nxt, bw_r, bh_r;
  kind_t              kind_o_r;

  assign den_nxt = SIZE_VW'(cam_dist) + DEN_OFFSET;

  always_comb begin
    case (kind)
      KIND_PLAYER: k_sel = K_PLAYER;
      KIND_NPC:    k_sel = K_NPC;
      default:     k_sel = K_GADGET;
    endcase
  end

  assign dvd_nxt = k_sel + SZ_DW'(den_nxt >> 1);

  pmb_div #(
    .VW(SIZE_VW),
    .QW(SIZE_Q)
  ) u_div (
    .clk(clk),
    .en (en),
    .dvd(dvd_r),
    .dvs(den_r),
    .q  (raw)
  );

  always_comb begin
    case (kind_r[SIZE_Q])
      KIND_PLAYER: begin
        if (raw > 13'd1280) begin
          bh_nxt = 11'd1280;
        end else if (raw < 13'd192) begin
          bh_nxt = 11'd192;
        end else begin
          bh_nxt = BOX_W'(raw);
        end
        bw_nxt = bh_nxt >> 1;
        if (bh_nxt < 11'd320) begin
          bh_nxt = 11'd320;
          bw_nxt = 11'd160;
        end
      end
      KIND_NPC: begin
        if (raw > 13'd960) begin
          bh_nxt = 11'd960;
        end else if (raw < 13'd240) begin
          bh_nxt = 11'd240;
        end else begin
          bh_nxt = BOX_W'(raw);
        end
        bw_nxt = bh_nxt;
      end
      default: begin
        if (raw > 13'd256) begin
          bh_nxt = 11'd256;
        end else if (raw < 13'd64) begin
          bh_nxt = 11'd64;
        end else begin
          bh_nxt = BOX_W'(raw);
        end
        bw_nxt = bh_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r     <= den_nxt;
      dvd_r     <= dvd_nxt;
      kind_r[0] <= kind;
      for (int k = 1; k <= SIZE_Q; k++) begin
        kind_r[k] <= kind_r[k-1];
      end
      bw_r     <= bw_nxt;
      bh_r     <= bh_nxt;
      kind_o_r <= kind_r[SIZE_Q];
    end
  end

  assign box_w  = bw_r;
  assign box_h  = bh_r;
  assign kind_o = kind_o_r;

endmodule
